// File: hdl/blts_pkg.sv
// Package for the BASIC token scanner: item types, token codes and keyword lookup.
`default_nettype none
package blts_pkg;

  // One input item.
  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } in_t;

  // One result item.
  typedef struct packed {
    logic [5:0]  token_kind;
    logic [1:0]  error_code;
    logic [15:0] line;
    logic [31:0] start_offset;
    logic [15:0] lexeme_length;
    logic        bool_value;
    logic        last_of_text;
  } out_t;

  // Up to three results from one item.
  typedef struct packed {
    out_t [2:0] r;
    logic [1:0] n;
  } res_set_t;

  // Token kinds
  localparam logic [5:0] TK_LPAREN = 6'd0;
  localparam logic [5:0] TK_RPAREN = 6'd1;
  localparam logic [5:0] TK_COMMA  = 6'd2;
  localparam logic [5:0] TK_MINUS  = 6'd3;
  localparam logic [5:0] TK_PLUS   = 6'd4;
  localparam logic [5:0] TK_STAR   = 6'd5;
  localparam logic [5:0] TK_SLASH  = 6'd6;
  localparam logic [5:0] TK_ASSIGN = 6'd7;
  localparam logic [5:0] TK_EQEQ   = 6'd8;
  localparam logic [5:0] TK_LT     = 6'd9;
  localparam logic [5:0] TK_LE     = 6'd10;
  localparam logic [5:0] TK_NE     = 6'd11;
  localparam logic [5:0] TK_GT     = 6'd12;
  localparam logic [5:0] TK_GE     = 6'd13;
  localparam logic [5:0] TK_STRING = 6'd14;
  localparam logic [5:0] TK_NUMBER = 6'd15;
  localparam logic [5:0] TK_IDENT  = 6'd16;
  localparam logic [5:0] TK_BOOL   = 6'd17;
  localparam logic [5:0] TK_KW0    = 6'd18;
  localparam logic [5:0] TK_END    = 6'd35;

  // Error codes
  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_CHAR  = 2'd1;
  localparam logic [1:0] ERR_STRNG = 2'd2;

  // Word table indexes
  localparam logic [4:0] KW_REM   = 5'd17;
  localparam logic [4:0] KW_TRUE  = 5'd18;
  localparam logic [4:0] KW_FALSE = 5'd19;
  localparam logic [4:0] KW_NONE  = 5'd31;
  localparam int         NUM_WORDS = 20;

  // Word text, left justified, first character in the top byte.
  function automatic logic [63:0] kw_text(input logic [4:0] i);
    logic [63:0] t;
    case (i)
      5'd0:    t = {"let", 40'd0};
      5'd1:    t = {"input", 24'd0};
      5'd2:    t = {"print", 24'd0};
      5'd3:    t = {"tonum", 24'd0};
      5'd4:    t = {"tostr", 24'd0};
      5'd5:    t = {"rnd", 40'd0};
      5'd6:    t = {"if", 48'd0};
      5'd7:    t = {"then", 32'd0};
      5'd8:    t = {"else", 32'd0};
      5'd9:    t = {"end", 40'd0};
      5'd10:   t = {"while", 24'd0};
      5'd11:   t = {"do", 48'd0};
      5'd12:   t = {"break", 24'd0};
      5'd13:   t = "continue";
      5'd14:   t = {"not", 40'd0};
      5'd15:   t = {"and", 40'd0};
      5'd16:   t = {"or", 48'd0};
      5'd17:   t = {"rem", 40'd0};
      5'd18:   t = {"true", 32'd0};
      5'd19:   t = {"false", 24'd0};
      default: t = '0;
    endcase
    return t;
  endfunction

  function automatic logic [3:0] kw_len(input logic [4:0] i);
    logic [3:0] n;
    case (i)
      5'd0, 5'd5, 5'd9, 5'd14, 5'd15, 5'd17: n = 4'd3;
      5'd6, 5'd11, 5'd16:                     n = 4'd2;
      5'd7, 5'd8, 5'd18:                      n = 4'd4;
      5'd13:                                  n = 4'd8;
      5'd1, 5'd2, 5'd3, 5'd4, 5'd10, 5'd12, 5'd19: n = 4'd5;
      default:                                n = 4'd0;
    endcase
    return n;
  endfunction

  // Parallel compare of a word against the table; KW_NONE if no match.
  function automatic logic [4:0] kw_lookup(input logic [63:0] w, input logic [3:0] n);
    logic [4:0]  idx;
    logic [63:0] mask;
    idx  = KW_NONE;
    mask = ~(64'hFFFF_FFFF_FFFF_FFFF >> {n, 3'd0});
    for (int i = NUM_WORDS - 1; i >= 0; i--) begin
      if (kw_len(5'(i)) == n && ((w ^ kw_text(5'(i))) & mask) == 64'd0) begin
        idx = 5'(i);
      end
    end
    return idx;
  endfunction

  // Append one result.
  function automatic res_set_t add(input res_set_t s, input out_t t);
    res_set_t o;
    o = s;
    o.r[s.n] = t;
    o.n = s.n + 2'd1;
    return o;
  endfunction

endpackage
`default_nettype wire

// File: hdl/basic_lexer_token_scanner_unit.sv
// Top level of the BASIC token scanner: scan state, token building and result queue.
`default_nettype none
// Takes one text byte per cycle and gives tokens through a four-entry result
// queue. Each byte is handled in the cycle it is accepted; it may give up to three
// tokens, which leave one per cycle while out_stall_i is low, so the input stalls
// while more than one result is queued. For typical text the rate is one byte per
// cycle. An error result stops further results until the item marked end_of_text.
// The user must write first_line only while the block is idle; the block won't check.
module basic_lexer_token_scanner_unit #(
  parameter int KEYWORD_CHARS = 8,
  parameter int LENGTH_BITS   = 16,
  parameter int LINE_BITS     = 16,
  parameter int OFFSET_BITS   = 32
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cfg_we_i,
  input  wire logic [15:0]     cfg_wdata_i,
  input  wire logic            in_valid_i,
  output      logic            in_stall_o,
  input  wire blts_pkg::in_t   in_item_i,
  output      logic            out_valid_o,
  input  wire logic            out_stall_i,
  output      blts_pkg::out_t  out_item_o
);

  localparam int WI = $clog2(KEYWORD_CHARS);

  // Scan modes
  localparam logic [3:0] M_IDLE    = 4'd0;
  localparam logic [3:0] M_IDENT   = 4'd1;
  localparam logic [3:0] M_NUMBER  = 4'd2;
  localparam logic [3:0] M_STRING  = 4'd3;
  localparam logic [3:0] M_COMMENT = 4'd4;
  localparam logic [3:0] M_EQ      = 4'd5;
  localparam logic [3:0] M_LT      = 4'd6;
  localparam logic [3:0] M_GT      = 4'd7;
  localparam logic [3:0] M_DRAIN   = 4'd8;

  logic [3:0]             mode_q, mode_d;
  logic [OFFSET_BITS-1:0] start_q, start_d;
  logic [LENGTH_BITS-1:0] len_q, len_d;
  logic [OFFSET_BITS-1:0] pos_q, pos_d;
  logic [LINE_BITS-1:0]   line_q, line_d;
  logic                   fresh_q, fresh_d;
  logic [15:0]            first_line_q;
  logic [7:0]             wbuf_q [KEYWORD_CHARS];
  logic                   wb_we;
  logic [WI-1:0]          wb_idx;
  logic [7:0]             wb_data;

  blts_pkg::out_t   fifo_q [4];
  logic [1:0]       wr_ptr_q, rd_ptr_q;
  logic [2:0]       cnt_q;
  logic             in_fire, pop;
  blts_pkg::res_set_t rs;

  assign in_stall_o  = cnt_q > 3'd1;
  assign in_fire     = in_valid_i && !in_stall_o;
  assign out_valid_o = cnt_q != 3'd0;
  assign pop         = out_valid_o && !out_stall_i;
  assign out_item_o  = fifo_q[rd_ptr_q];

  function automatic blts_pkg::out_t mk(input logic [5:0] kind, input logic [1:0] err,
      input logic [LINE_BITS-1:0] ln, input logic [OFFSET_BITS-1:0] st,
      input logic [LENGTH_BITS-1:0] lg, input logic bv, input logic last);
    blts_pkg::out_t t;
    t.token_kind    = kind;
    t.error_code    = err;
    t.line          = 16'(ln);
    t.start_offset  = 32'(st);
    t.lexeme_length = 16'(lg);
    t.bool_value    = bv;
    t.last_of_text  = last;
    return t;
  endfunction

  // Per-byte scan step
  always_comb begin
    logic [7:0]  b;
    logic        eot, is_dig, is_alp, go_idle, do_end, failed;
    logic [7:0]  lc;
    logic [63:0] w;
    logic [4:0]  idx;
    logic [5:0]  kind;
    logic [63:0] w_end;
    logic [4:0]  idx_end;
    logic [5:0]  kind_end;
    b       = in_item_i.text_byte;
    eot     = in_item_i.end_of_text;
    mode_d  = mode_q;
    start_d = start_q;
    len_d   = len_q;
    pos_d   = pos_q;
    line_d  = line_q;
    fresh_d = fresh_q;
    wb_we   = 1'b0;
    wb_idx  = len_q[WI-1:0];
    wb_data = '0;
    rs      = '0;
    go_idle = 1'b0;
    do_end  = 1'b0;
    failed  = 1'b0;
    is_dig  = b >= "0" && b <= "9";
    is_alp  = (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
    lc      = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
    idx     = blts_pkg::KW_NONE;
    kind    = blts_pkg::TK_IDENT;
    w_end   = '0;
    idx_end = blts_pkg::KW_NONE;
    kind_end = blts_pkg::TK_IDENT;
    // keyword compare on the buffered word
    for (int j = 0; j < 8; j++) begin
      w[8*(7-j) +: 8] = wbuf_q[j];
    end
    if (len_q <= LENGTH_BITS'(KEYWORD_CHARS) && len_q <= LENGTH_BITS'(8)) begin
      idx = blts_pkg::kw_lookup(w, len_q[3:0]);
    end
    if (idx < blts_pkg::KW_REM) begin
      kind = blts_pkg::TK_KW0 + 6'(idx);
    end else if (idx == blts_pkg::KW_TRUE || idx == blts_pkg::KW_FALSE) begin
      kind = blts_pkg::TK_BOOL;
    end

    if (in_fire) begin
      if (mode_q == M_DRAIN) begin
        if (eot) begin
          mode_d = M_IDLE; start_d = '0; len_d = '0; pos_d = '0; fresh_d = 1'b1;
        end
      end else begin
        if (fresh_q) begin
          line_d  = LINE_BITS'(first_line_q);
          fresh_d = 1'b0;
        end
        if (b == 8'd0) begin
          do_end = 1'b1;
        end else begin
          // close or extend the pending token
          case (mode_q)
            M_IDENT: begin
              if (is_alp || is_dig) begin
                if (len_q < LENGTH_BITS'(KEYWORD_CHARS)) begin
                  wb_we = 1'b1; wb_data = lc;
                end
                if (len_d != '1) len_d = len_d + LENGTH_BITS'(1);
              end else if (idx == blts_pkg::KW_REM) begin
                mode_d = M_COMMENT;
                if (b == "\n") begin
                  if (line_d != '1) line_d = line_d + LINE_BITS'(1);
                  mode_d = M_IDLE;
                end
              end else begin
                rs = blts_pkg::add(rs, mk(kind, blts_pkg::ERR_NONE, line_d, start_q, len_q,
                                          idx == blts_pkg::KW_TRUE, 1'b0));
                mode_d  = M_IDLE;
                go_idle = 1'b1;
              end
            end
            M_NUMBER: begin
              if (is_dig || b == ".") begin
                if (len_d != '1) len_d = len_d + LENGTH_BITS'(1);
              end else begin
                rs = blts_pkg::add(rs, mk(blts_pkg::TK_NUMBER, blts_pkg::ERR_NONE, line_d,
                                          start_q, len_q, 1'b0, 1'b0));
                mode_d  = M_IDLE;
                go_idle = 1'b1;
              end
            end
            M_STRING: begin
              if (len_d != '1) len_d = len_d + LENGTH_BITS'(1);
              if (b == "\"") begin
                rs = blts_pkg::add(rs, mk(blts_pkg::TK_STRING, blts_pkg::ERR_NONE, line_d,
                                          start_q, len_d, 1'b0, 1'b0));
                mode_d = M_IDLE;
              end else if (b == "\n") begin
                if (line_d != '1) line_d = line_d + LINE_BITS'(1);
              end
            end
            M_COMMENT: begin
              if (b == "\n") begin
                if (line_d != '1) line_d = line_d + LINE_BITS'(1);
                mode_d = M_IDLE;
              end
            end
            M_EQ: begin
              mode_d = M_IDLE;
              if (b == "=") begin
                rs = blts_pkg::add(rs, mk(blts_pkg::TK_EQEQ, blts_pkg::ERR_NONE, line_d,
                                          start_q, LENGTH_BITS'(2), 1'b0, 1'b0));
              end else begin
                rs = blts_pkg::add(rs, mk(blts_pkg::TK_ASSIGN, blts_pkg::ERR_NONE, line_d,
                                          start_q, LENGTH_BITS'(1), 1'b0, 1'b0));
                go_idle = 1'b1;
              end
            end
            M_LT: begin
              mode_d = M_IDLE;
              if (b == "=") begin
                rs = blts_pkg::add(rs, mk(blts_pkg::TK_LE, blts_pkg::ERR_NONE, line_d,
                                          start_q, LENGTH_BITS'(2), 1'b0, 1'b0));
              end else if (b == ">") begin
                rs = blts_pkg::add(rs, mk(blts_pkg::TK_NE, blts_pkg::ERR_NONE, line_d,
                                          start_q, LENGTH_BITS'(2), 1'b0, 1'b0));
              end else begin
                rs = blts_pkg::add(rs, mk(blts_pkg::TK_LT, blts_pkg::ERR_NONE, line_d,
                                          start_q, LENGTH_BITS'(1), 1'b0, 1'b0));
                go_idle = 1'b1;
              end
            end
            M_GT: begin
              mode_d = M_IDLE;
              if (b == "=") begin
                rs = blts_pkg::add(rs, mk(blts_pkg::TK_GE, blts_pkg::ERR_NONE, line_d,
                                          start_q, LENGTH_BITS'(2), 1'b0, 1'b0));
              end else begin
                rs = blts_pkg::add(rs, mk(blts_pkg::TK_GT, blts_pkg::ERR_NONE, line_d,
                                          start_q, LENGTH_BITS'(1), 1'b0, 1'b0));
                go_idle = 1'b1;
              end
            end
            default: begin
              mode_d  = M_IDLE;
              go_idle = 1'b1;
            end
          endcase

          // start of a new token
          if (go_idle) begin
            case (b)
              "(": rs = blts_pkg::add(rs, mk(blts_pkg::TK_LPAREN, blts_pkg::ERR_NONE, line_d,
                                            pos_q, LENGTH_BITS'(1), 1'b0, 1'b0));
              ")": rs = blts_pkg::add(rs, mk(blts_pkg::TK_RPAREN, blts_pkg::ERR_NONE, line_d,
                                            pos_q, LENGTH_BITS'(1), 1'b0, 1'b0));
              ",": rs = blts_pkg::add(rs, mk(blts_pkg::TK_COMMA, blts_pkg::ERR_NONE, line_d,
                                            pos_q, LENGTH_BITS'(1), 1'b0, 1'b0));
              "-": rs = blts_pkg::add(rs, mk(blts_pkg::TK_MINUS, blts_pkg::ERR_NONE, line_d,
                                            pos_q, LENGTH_BITS'(1), 1'b0, 1'b0));
              "+": rs = blts_pkg::add(rs, mk(blts_pkg::TK_PLUS, blts_pkg::ERR_NONE, line_d,
                                            pos_q, LENGTH_BITS'(1), 1'b0, 1'b0));
              "*": rs = blts_pkg::add(rs, mk(blts_pkg::TK_STAR, blts_pkg::ERR_NONE, line_d,
                                            pos_q, LENGTH_BITS'(1), 1'b0, 1'b0));
              "/": rs = blts_pkg::add(rs, mk(blts_pkg::TK_SLASH, blts_pkg::ERR_NONE, line_d,
                                            pos_q, LENGTH_BITS'(1), 1'b0, 1'b0));
              "=": begin mode_d = M_EQ; start_d = pos_q; len_d = LENGTH_BITS'(1); end
              "<": begin mode_d = M_LT; start_d = pos_q; len_d = LENGTH_BITS'(1); end
              ">": begin mode_d = M_GT; start_d = pos_q; len_d = LENGTH_BITS'(1); end
              " ", 8'd13, 8'd9: ;
              "\n": if (line_d != '1) line_d = line_d + LINE_BITS'(1);
              "\"": begin mode_d = M_STRING; start_d = pos_q; len_d = LENGTH_BITS'(1); end
              default: begin
                if (is_dig) begin
                  mode_d = M_NUMBER; start_d = pos_q; len_d = LENGTH_BITS'(1);
                end else if (is_alp) begin
                  mode_d = M_IDENT; start_d = pos_q; len_d = LENGTH_BITS'(1);
                  wb_we = 1'b1; wb_idx = '0; wb_data = lc;
                end else begin
                  rs = blts_pkg::add(rs, mk(blts_pkg::TK_LPAREN, blts_pkg::ERR_CHAR, line_d,
                                            pos_q, LENGTH_BITS'(1), 1'b0, 1'b1));
                  mode_d = M_DRAIN;
                end
              end
            endcase
          end

          pos_d = pos_q + OFFSET_BITS'(1);
          if (mode_d == M_DRAIN) begin
            if (eot) begin
              mode_d = M_IDLE; start_d = '0; len_d = '0; pos_d = '0; fresh_d = 1'b1;
            end
          end else if (eot) begin
            do_end = 1'b1;
          end
        end

        // end of text or zero byte: flush the pending token, then the end token if no error
        if (do_end) begin
          case (mode_d)
            M_IDENT: begin
              // word as it stands after this byte
              for (int j = 0; j < 8; j++) begin
                w_end[8*(7-j) +: 8] = (wb_we && int'(wb_idx) == j) ? wb_data : wbuf_q[j];
              end
              if (len_d <= LENGTH_BITS'(KEYWORD_CHARS) && len_d <= LENGTH_BITS'(8)) begin
                idx_end = blts_pkg::kw_lookup(w_end, len_d[3:0]);
              end
              if (idx_end < blts_pkg::KW_REM) begin
                kind_end = blts_pkg::TK_KW0 + 6'(idx_end);
              end else if (idx_end == blts_pkg::KW_TRUE || idx_end == blts_pkg::KW_FALSE) begin
                kind_end = blts_pkg::TK_BOOL;
              end
              if (idx_end != blts_pkg::KW_REM) begin
                rs = blts_pkg::add(rs, mk(kind_end, blts_pkg::ERR_NONE, line_d, start_d,
                                          len_d, idx_end == blts_pkg::KW_TRUE, 1'b0));
              end
            end
            M_NUMBER: rs = blts_pkg::add(rs, mk(blts_pkg::TK_NUMBER, blts_pkg::ERR_NONE, line_d,
                                                start_d, len_d, 1'b0, 1'b0));
            M_EQ: rs = blts_pkg::add(rs, mk(blts_pkg::TK_ASSIGN, blts_pkg::ERR_NONE, line_d,
                                            start_d, LENGTH_BITS'(1), 1'b0, 1'b0));
            M_LT: rs = blts_pkg::add(rs, mk(blts_pkg::TK_LT, blts_pkg::ERR_NONE, line_d,
                                            start_d, LENGTH_BITS'(1), 1'b0, 1'b0));
            M_GT: rs = blts_pkg::add(rs, mk(blts_pkg::TK_GT, blts_pkg::ERR_NONE, line_d,
                                            start_d, LENGTH_BITS'(1), 1'b0, 1'b0));
            M_STRING: begin
              rs = blts_pkg::add(rs, mk(blts_pkg::TK_LPAREN, blts_pkg::ERR_STRNG, line_d,
                                        start_d, len_d, 1'b0, 1'b1));
              failed = 1'b1;
            end
            default: ;
          endcase
          if (!failed) begin
            rs = blts_pkg::add(rs, mk(blts_pkg::TK_END, blts_pkg::ERR_NONE, line_d, pos_d,
                                      '0, 1'b0, 1'b1));
          end
          if (eot) begin
            mode_d = M_IDLE; start_d = '0; len_d = '0; pos_d = '0; fresh_d = 1'b1;
          end else begin
            mode_d = M_DRAIN;
          end
        end
      end
    end
  end

  // Scan state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= M_IDLE;
      start_q      <= '0;
      len_q        <= '0;
      pos_q        <= '0;
      line_q       <= LINE_BITS'(1);
      fresh_q      <= 1'b1;
      first_line_q <= 16'd1;
    end else begin
      mode_q  <= mode_d;
      start_q <= start_d;
      len_q   <= len_d;
      pos_q   <= pos_d;
      line_q  <= line_d;
      fresh_q <= fresh_d;
      if (cfg_we_i) first_line_q <= cfg_wdata_i;
    end
  end

  // Word buffer, lower-cased leading characters of an identifier
  always_ff @(posedge clk_i) begin
    if (wb_we) wbuf_q[wb_idx] <= wb_data;
  end

  // Result queue payload
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      if (2'(k) < rs.n) fifo_q[wr_ptr_q + 2'(k)] <= rs.r[k];
    end
  end

  // Result queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + rs.n;
      rd_ptr_q <= rd_ptr_q + 2'(pop);
      cnt_q    <= cnt_q + 3'(rs.n) - 3'(pop);
    end
  end

  // Queue count tracks pushes and pops
  a_cnt_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> cnt_q == $past(cnt_q) + 3'($past(rs.n)) - 3'($past(pop)))
    else $error("result queue count mismatch");

  // Queue never overflows
  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 3'd4)
    else $error("result queue overflow");

  // Halted scanner gives no results
  a_drain_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == M_DRAIN |-> rs.n == 2'd0)
    else $error("result while halted");

endmodule
`default_nettype wire
